// ----- rtl/lsq_pkg.sv -----
package lsq_pkg;

    localparam int X_W             = 16;
    localparam int X_FRAC          = 8;
    localparam int COEF_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int SAT_W           = 48;
    localparam int PRED_W          = COEF_W + X_W + 1;
    localparam int DIV_Q_W         = 32;
    localparam int DIV_CNT_W       = $clog2(DIV_Q_W + 1);
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int CNT_W_DEF       = $clog2(MAX_SAMPLES_DEF + 1);
    localparam int DIV_W_DEF       = 2 * CNT_W_DEF + 2 * X_W;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_PREDICT = 1'b1;
    localparam logic KIND_FIT     = 1'b0;
    localparam logic KIND_PRED    = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR   = 2'd1;
    localparam logic [1:0] ST_NO_SAMPLES = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    typedef struct packed {
        logic                    func;
        logic signed [X_W-1:0]   x_value;
        logic signed [X_W-1:0]   y_value;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic                     kind;
        logic signed [COEF_W-1:0] intercept;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] prediction;
        logic [1:0]               status;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_PLOAD,
        OP_PMUL,
        OP_PADD,
        OP_PABS,
        OP_POUT,
        OP_FM1,
        OP_FM2,
        OP_FNUM,
        OP_FABS,
        OP_FCHK,
        OP_SDIV,
        OP_SFIN,
        OP_IMUL,
        OP_ISUB,
        OP_IABS,
        OP_ICHK,
        OP_IDIV,
        OP_IFIN,
        OP_FOUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic fit_err;
        logic big;
    } t_sts;

    // Signed result from sign and magnitude, clamped to the 32-bit range.
    function automatic logic signed [COEF_W-1:0] sat32(input logic neg,
                                                       input logic [SAT_W-1:0] mag);
        logic [COEF_W-1:0] m32;
        m32 = {1'b0, mag[COEF_W-2:0]};
        if (mag[SAT_W-1:COEF_W-1] != '0) begin
            return neg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end
        return neg ? (~m32 + 1'b1) : m32;
    endfunction

endpackage

// ----- rtl/lsq_div.sv -----
module lsq_div #(
    parameter int DW = lsq_pkg::DIV_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_rinit,
    input  logic [lsq_pkg::DIV_Q_W-1:0] i_low,
    input  logic [DW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [lsq_pkg::DIV_Q_W-1:0] o_quot,
    output logic [DW-1:0]               o_rem
);

    localparam int QW = lsq_pkg::DIV_Q_W;
    localparam int CW = lsq_pkg::DIV_CNT_W;

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rinit;
            r_low <= i_low;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low  <= {r_low[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("Partial remainder is not below the divisor.");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Division started while one is still running.");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Division done lasted more than one cycle.");
`endif

endmodule

// ----- rtl/lsq_dp.sv -----
module lsq_dp #(
    parameter int MAX_SAMPLES = lsq_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsq_pkg::t_cmd      i_cmd,
    input  lsq_pkg::t_in_item  i_item,
    input  logic               i_out_stall,
    output lsq_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output lsq_pkg::t_out_item o_out_item
);

    localparam int XW       = lsq_pkg::X_W;
    localparam int XF       = lsq_pkg::X_FRAC;
    localparam int KW       = lsq_pkg::COEF_W;
    localparam int QW       = lsq_pkg::DIV_Q_W;
    localparam int SW       = lsq_pkg::SAT_W;
    localparam int PW       = lsq_pkg::PRED_W;
    localparam int CW       = $clog2(MAX_SAMPLES + 1);
    localparam int SXW      = XW + CW;
    localparam int SQW      = 2 * XW - 1 + CW;
    localparam int NW       = 2 * CW + 2 * XW;
    localparam int TW       = SXW + KW + 1;
    localparam int SLOPE_SH = QW - lsq_pkg::FRAC_W - 1;
    localparam int INT_SH   = XF + QW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    logic [CW-1:0]          r_cnt;
    logic signed [SXW-1:0]  r_sx;
    logic signed [SXW-1:0]  r_sy;
    logic signed [SQW-1:0]  r_sxx;
    logic signed [SQW-1:0]  r_sxy;
    logic                   r_ovf;
    logic signed [KW-1:0]   r_cslope;
    logic signed [KW-1:0]   r_cicpt;
    logic                   r_out_valid;

    logic signed [NW-1:0]   r_pa;
    logic signed [NW-1:0]   r_pb;
    logic signed [NW-1:0]   r_den;
    logic signed [NW-1:0]   r_num;
    logic                   r_neg;
    logic [NW-1:0]          r_mag;
    logic [1:0]             r_status;
    logic                   r_big;
    logic signed [KW-1:0]   r_slope;
    logic signed [KW-1:0]   r_icpt;
    logic signed [TW-2:0]   r_tp;
    logic signed [TW-1:0]   r_t;
    logic                   r_ineg;
    logic [TW-1:0]          r_imag;
    logic signed [XW-1:0]   r_px;
    logic signed [KW+XW-1:0] r_pp;
    logic signed [PW-1:0]   r_p;
    logic                   r_pneg;
    logic [PW-1:0]          r_pmag;
    lsq_pkg::t_out_item     r_out;

    logic signed [2*XW-1:0] w_xx;
    logic signed [2*XW-1:0] w_xy;
    logic                   w_sel_xy;
    logic signed [SQW-1:0]  w_ma;
    logic signed [SXW-1:0]  w_mb;
    logic signed [NW-1:0]   w_pa;
    logic signed [NW-1:0]   w_pb;
    logic signed [TW-2:0]   w_tp;
    logic signed [SXW+15:0] w_sy16;
    logic signed [KW+XW-1:0] w_pp;
    logic signed [PW-1:0]   w_icpt_sh;
    logic                   w_is_idiv;
    logic                   w_div_start;
    logic [NW-1:0]          w_div_rinit;
    logic [QW-1:0]          w_div_low;
    logic [NW-1:0]          w_div_divisor;
    logic                   w_div_done;
    logic [QW-1:0]          w_q;
    logic [NW-1:0]          w_rem;
    logic [SW-1:0]          w_smag;
    logic                   w_round;
    logic [SW-1:0]          w_imag;
    logic [SW-1:0]          w_pq;
    logic                   w_err;
    logic signed [KW-1:0]   w_fit_slope;
    logic signed [KW-1:0]   w_fit_icpt;
    logic                   w_load;

    assign w_xx = $signed(i_item.x_value) * $signed(i_item.x_value);
    assign w_xy = $signed(i_item.x_value) * $signed(i_item.y_value);

    assign w_sel_xy = (i_cmd.op == lsq_pkg::OP_FM2);
    assign w_ma     = w_sel_xy ? r_sxy : r_sxx;
    assign w_mb     = w_sel_xy ? r_sy : r_sx;
    assign w_pa     = $signed({1'b0, r_cnt}) * w_ma;
    assign w_pb     = r_sx * w_mb;
    assign w_tp     = r_slope * r_sx;
    assign w_sy16   = {r_sy, 16'b0};
    assign w_pp     = r_cslope * r_px;
    assign w_icpt_sh = $signed({r_cicpt, {XF{1'b0}}});

    assign w_is_idiv     = (i_cmd.op == lsq_pkg::OP_IDIV);
    assign w_div_start   = (i_cmd.op == lsq_pkg::OP_SDIV) || w_is_idiv;
    assign w_div_rinit   = w_is_idiv ? NW'(r_imag[TW-1:QW]) : (r_mag >> SLOPE_SH);
    assign w_div_low     = w_is_idiv ? r_imag[QW-1:0]
                                     : {r_mag[SLOPE_SH-1:0], {(QW-SLOPE_SH){1'b0}}};
    assign w_div_divisor = w_is_idiv ? NW'({r_cnt, {XF{1'b0}}}) : r_den;

    lsq_div #(.DW(NW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rinit   (w_div_rinit),
        .i_low     (w_div_low),
        .i_divisor (w_div_divisor),
        .o_done    (w_div_done),
        .o_quot    (w_q),
        .o_rem     (w_rem)
    );

    assign w_smag  = r_big ? SW'({1'b1, {QW{1'b0}}})
                           : SW'(({1'b0, w_q} + (QW+1)'(1)) >> 1);
    assign w_round = {w_rem, 1'b0} >= (NW+1)'({r_cnt, {XF{1'b0}}});
    assign w_imag  = r_big ? SW'({1'b1, {QW{1'b0}}}) : (SW'(w_q) + SW'(w_round));
    assign w_pq    = SW'(r_pmag[PW-1:XF]) + SW'(r_pmag[XF-1]);

    assign w_err       = (r_status != lsq_pkg::ST_OK);
    assign w_fit_slope = w_err ? '0 : r_slope;
    assign w_fit_icpt  = w_err ? '0 : r_icpt;
    assign w_load      = (i_cmd.op == lsq_pkg::OP_FOUT) || (i_cmd.op == lsq_pkg::OP_POUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_ovf       <= 1'b0;
            r_cslope    <= '0;
            r_cicpt     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                lsq_pkg::OP_SAMPLE: begin
                    if (r_cnt == MAX_CNT) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sx  <= r_sx + SXW'($signed(i_item.x_value));
                        r_sy  <= r_sy + SXW'($signed(i_item.y_value));
                        r_sxx <= r_sxx + SQW'(w_xx);
                        r_sxy <= r_sxy + SQW'(w_xy);
                    end
                end
                lsq_pkg::OP_FOUT: begin
                    r_cnt    <= '0;
                    r_sx     <= '0;
                    r_sy     <= '0;
                    r_sxx    <= '0;
                    r_sxy    <= '0;
                    r_ovf    <= 1'b0;
                    r_cslope <= w_fit_slope;
                    r_cicpt  <= w_fit_icpt;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lsq_pkg::OP_PLOAD: r_px <= i_item.x_value;
            lsq_pkg::OP_PMUL:  r_pp <= w_pp;
            lsq_pkg::OP_PADD:  r_p  <= r_pp + w_icpt_sh;
            lsq_pkg::OP_PABS: begin
                r_pneg <= r_p[PW-1];
                r_pmag <= r_p[PW-1] ? -r_p : r_p;
            end
            lsq_pkg::OP_POUT: begin
                r_out.kind       <= lsq_pkg::KIND_PRED;
                r_out.intercept  <= r_cicpt;
                r_out.slope      <= r_cslope;
                r_out.prediction <= lsq_pkg::sat32(r_pneg, w_pq);
                r_out.status     <= lsq_pkg::ST_OK;
            end
            lsq_pkg::OP_FM1: begin
                r_pa <= w_pa;
                r_pb <= w_pb;
            end
            lsq_pkg::OP_FM2: begin
                r_den <= r_pa - r_pb;
                r_pa  <= w_pa;
                r_pb  <= w_pb;
            end
            lsq_pkg::OP_FNUM: r_num <= r_pa - r_pb;
            lsq_pkg::OP_FABS: begin
                r_neg <= r_num[NW-1];
                r_mag <= r_num[NW-1] ? -r_num : r_num;
                if (r_ovf) begin
                    r_status <= lsq_pkg::ST_OVERFLOW;
                end else if (r_cnt == '0) begin
                    r_status <= lsq_pkg::ST_NO_SAMPLES;
                end else if (r_den == '0) begin
                    r_status <= lsq_pkg::ST_ZERO_VAR;
                end else begin
                    r_status <= lsq_pkg::ST_OK;
                end
            end
            lsq_pkg::OP_FCHK: begin
                r_big <= {{SLOPE_SH{1'b0}}, r_mag} >= {r_den, {SLOPE_SH{1'b0}}};
            end
            lsq_pkg::OP_SFIN: r_slope <= lsq_pkg::sat32(r_neg, w_smag);
            lsq_pkg::OP_IMUL: r_tp <= w_tp;
            lsq_pkg::OP_ISUB: r_t <= w_sy16 - r_tp;
            lsq_pkg::OP_IABS: begin
                r_ineg <= r_t[TW-1];
                r_imag <= r_t[TW-1] ? -r_t : r_t;
            end
            lsq_pkg::OP_ICHK: r_big <= r_imag >= TW'({r_cnt, {INT_SH{1'b0}}});
            lsq_pkg::OP_IFIN: r_icpt <= lsq_pkg::sat32(r_ineg, w_imag);
            lsq_pkg::OP_FOUT: begin
                r_out.kind       <= lsq_pkg::KIND_FIT;
                r_out.intercept  <= w_fit_icpt;
                r_out.slope      <= w_fit_slope;
                r_out.prediction <= '0;
                r_out.status     <= r_status;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.fit_err  = w_err;
    assign o_sts.big      = r_big;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

// ----- rtl/lsq_ctrl.sv -----
module lsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lsq_pkg::t_in_item i_in_item,
    input  lsq_pkg::t_sts     i_sts,
    output logic              o_in_stall,
    output lsq_pkg::t_cmd     o_cmd
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_PMUL  = 21'h000002,
        S_PADD  = 21'h000004,
        S_PABS  = 21'h000008,
        S_POUT  = 21'h000010,
        S_FM1   = 21'h000020,
        S_FM2   = 21'h000040,
        S_FNUM  = 21'h000080,
        S_FABS  = 21'h000100,
        S_FCHK  = 21'h000200,
        S_SDIV  = 21'h000400,
        S_SWAIT = 21'h000800,
        S_SFIN  = 21'h001000,
        S_IMUL  = 21'h002000,
        S_ISUB  = 21'h004000,
        S_IABS  = 21'h008000,
        S_ICHK  = 21'h010000,
        S_IDIV  = 21'h020000,
        S_IWAIT = 21'h040000,
        S_IFIN  = 21'h080000,
        S_FOUT  = 21'h100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = lsq_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.func == lsq_pkg::FUNC_PREDICT) begin
                        o_cmd.op = lsq_pkg::OP_PLOAD;
                        n_state  = S_PMUL;
                    end else begin
                        o_cmd.op = lsq_pkg::OP_SAMPLE;
                        if (i_in_item.last) begin
                            n_state = S_FM1;
                        end
                    end
                end
            end
            S_PMUL: begin
                o_cmd.op = lsq_pkg::OP_PMUL;
                n_state  = S_PADD;
            end
            S_PADD: begin
                o_cmd.op = lsq_pkg::OP_PADD;
                n_state  = S_PABS;
            end
            S_PABS: begin
                o_cmd.op = lsq_pkg::OP_PABS;
                n_state  = S_POUT;
            end
            S_POUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = lsq_pkg::OP_POUT;
                    n_state  = S_IDLE;
                end
            end
            S_FM1: begin
                o_cmd.op = lsq_pkg::OP_FM1;
                n_state  = S_FM2;
            end
            S_FM2: begin
                o_cmd.op = lsq_pkg::OP_FM2;
                n_state  = S_FNUM;
            end
            S_FNUM: begin
                o_cmd.op = lsq_pkg::OP_FNUM;
                n_state  = S_FABS;
            end
            S_FABS: begin
                o_cmd.op = lsq_pkg::OP_FABS;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                o_cmd.op = lsq_pkg::OP_FCHK;
                n_state  = i_sts.fit_err ? S_FOUT : S_SDIV;
            end
            S_SDIV: begin
                if (i_sts.big) begin
                    n_state = S_SFIN;
                end else begin
                    o_cmd.op = lsq_pkg::OP_SDIV;
                    n_state  = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_SFIN;
                end
            end
            S_SFIN: begin
                o_cmd.op = lsq_pkg::OP_SFIN;
                n_state  = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.op = lsq_pkg::OP_IMUL;
                n_state  = S_ISUB;
            end
            S_ISUB: begin
                o_cmd.op = lsq_pkg::OP_ISUB;
                n_state  = S_IABS;
            end
            S_IABS: begin
                o_cmd.op = lsq_pkg::OP_IABS;
                n_state  = S_ICHK;
            end
            S_ICHK: begin
                o_cmd.op = lsq_pkg::OP_ICHK;
                n_state  = S_IDIV;
            end
            S_IDIV: begin
                if (i_sts.big) begin
                    n_state = S_IFIN;
                end else begin
                    o_cmd.op = lsq_pkg::OP_IDIV;
                    n_state  = S_IWAIT;
                end
            end
            S_IWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_IFIN;
                end
            end
            S_IFIN: begin
                o_cmd.op = lsq_pkg::OP_IFIN;
                n_state  = S_FOUT;
            end
            S_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = lsq_pkg::OP_FOUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == lsq_pkg::OP_FOUT || o_cmd.op == lsq_pkg::OP_POUT) |-> i_sts.out_free)
        else $error("Result register loaded while a result is still held.");
`endif

endmodule

// ----- rtl/least_squares_line_fit.sv -----
// Least-squares straight-line fit with prediction.
// Input channel (i_in_valid, o_in_stall, i_in_item): a sample item adds one signed
// Q8.8 (x, y) pair to the running sums; the sample marked last also starts the fit.
// A predict item returns intercept + slope * x from the stored coefficients.
// Output channel (o_out_valid, i_out_stall, o_out_item): one item per fit or predict.
// A sample that is not last is accepted and the next item may follow at once.
// A predict item passes the load, multiply, add and absolute-value steps, then its
// result is loaded into the output register. In a fit the slope and the intercept
// each pass through one shared restoring divider that resolves one quotient bit per
// cycle; a saturated quotient skips its division, and a failed fit skips both.
// While a predict or a fit is in progress the input is stalled.
// The output register lets samples be accepted while a result waits to be taken;
// if the receiver stalls, a new result waits until the register is free.
// Reset clears the count, the sums, the overflow flag and the stored coefficients,
// so a predict before any fit returns zero.
module least_squares_line_fit #(
    parameter int MAX_SAMPLES = lsq_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lsq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lsq_pkg::t_out_item o_out_item
);

    lsq_pkg::t_cmd w_cmd;
    lsq_pkg::t_sts w_sts;

    lsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    lsq_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- verif/least_squares_line_fit_tb.sv -----
`timescale 1ns / 1ps

module least_squares_line_fit_tb;

    localparam longint SAMPLE_LIMIT = lsq_pkg::MAX_SAMPLES_DEF;
    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam int     CYCLE_LIMIT  = 1000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    lsq_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    lsq_pkg::t_out_item o_out_item;

    // Running fit state, mirrored from the accepted items.
    longint     sample_n;
    longint     acc_x;
    longint     acc_y;
    longint     acc_xx;
    longint     acc_xy;
    bit         overflow_seen;
    longint     coef_slope;
    longint     coef_icpt;

    lsq_pkg::t_out_item awaited_results[$];
    lsq_pkg::t_out_item want_item;
    int         mismatch_count;
    int         items_sent;
    int         cycle_count;
    bit         steady;

    least_squares_line_fit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_q16(input bit neg, input longint unsigned mag);
        if (neg) begin
            if (mag >= 64'h8000_0000) return Q_MIN;
            return -longint'(mag);
        end
        if (mag > 64'h7FFF_FFFF) return Q_MAX;
        return longint'(mag);
    endfunction

    // Division rounded to nearest, ties away from zero, then clamped to Q16.16.
    function automatic longint div_nearest(input longint t, input longint unsigned d);
        bit neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        neg = t < 0;
        mag = neg ? -t : t;
        q = mag / d;
        r = mag % d;
        if (r >= d - r) q++;
        return clamp_q16(neg, q);
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int any16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic lsq_pkg::t_in_item make_item(input logic f, input int x, input int y,
                                                    input logic l);
        lsq_pkg::t_in_item it;
        it.func    = f;
        it.x_value = 16'(x);
        it.y_value = 16'(y);
        it.last    = l;
        return it;
    endfunction

    task automatic model_line_fit(input lsq_pkg::t_in_item item);
        longint xv;
        longint yv;
        longint den;
        longint num;
        longint slope;
        longint icpt;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        longint unsigned m;
        bit neg;
        lsq_pkg::t_out_item res;
        xv  = longint'(item.x_value);
        yv  = longint'(item.y_value);
        res = '0;
        if (item.func == lsq_pkg::FUNC_PREDICT) begin
            res.kind       = lsq_pkg::KIND_PRED;
            res.intercept  = 32'(coef_icpt);
            res.slope      = 32'(coef_slope);
            res.prediction = 32'(div_nearest(coef_slope * xv + coef_icpt * 256, 256));
            res.status     = lsq_pkg::ST_OK;
            awaited_results.push_back(res);
            return;
        end
        if (sample_n >= SAMPLE_LIMIT) begin
            overflow_seen = 1'b1;
        end else begin
            sample_n++;
            acc_x  += xv;
            acc_y  += yv;
            acc_xx += xv * xv;
            acc_xy += xv * yv;
        end
        if (!item.last) return;
        slope = 0;
        icpt  = 0;
        den   = sample_n * acc_xx - acc_x * acc_x;
        num   = sample_n * acc_xy - acc_x * acc_y;
        if (overflow_seen) begin
            res.status = lsq_pkg::ST_OVERFLOW;
        end else if (sample_n == 0) begin
            res.status = lsq_pkg::ST_NO_SAMPLES;
        end else if (den == 0) begin
            res.status = lsq_pkg::ST_ZERO_VAR;
        end else begin
            res.status = lsq_pkg::ST_OK;
            neg = num < 0;
            mag = neg ? -num : num;
            q = mag / den;
            if (q >= 64'h8000) begin
                slope = neg ? Q_MIN : Q_MAX;
            end else begin
                r = mag % den;
                m = q;
                for (int i = 0; i < 17; i++) begin
                    r = r << 1;
                    m = m << 1;
                    if (r >= den) begin
                        r = r - den;
                        m = m | 64'd1;
                    end
                end
                slope = clamp_q16(neg, (m + 1) >> 1);
            end
            icpt = div_nearest(acc_y * 65536 - slope * acc_x, sample_n * 256);
        end
        coef_slope    = slope;
        coef_icpt     = icpt;
        sample_n      = 0;
        acc_x         = 0;
        acc_y         = 0;
        acc_xx        = 0;
        acc_xy        = 0;
        overflow_seen = 1'b0;
        res.kind      = lsq_pkg::KIND_FIT;
        res.intercept = 32'(icpt);
        res.slope     = 32'(slope);
        awaited_results.push_back(res);
    endtask

    task automatic send_item(input lsq_pkg::t_in_item item);
        while (!steady && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_line_fit(item);
        items_sent++;
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected item kind", -64'sd1, 64'(o_out_item.kind));
            end else begin
                want_item = awaited_results.pop_front();
                if (o_out_item.kind !== want_item.kind)
                    note_mismatch("kind", 64'(want_item.kind), 64'(o_out_item.kind));
                if (o_out_item.intercept !== want_item.intercept)
                    note_mismatch("intercept", 64'(want_item.intercept),
                                  64'(o_out_item.intercept));
                if (o_out_item.slope !== want_item.slope)
                    note_mismatch("slope", 64'(want_item.slope), 64'(o_out_item.slope));
                if (o_out_item.prediction !== want_item.prediction)
                    note_mismatch("prediction", 64'(want_item.prediction),
                                  64'(o_out_item.prediction));
                if (o_out_item.status !== want_item.status)
                    note_mismatch("status", 64'(want_item.status), 64'(o_out_item.status));
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 25);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("least_squares_line_fit verification failed");
            $finish;
        end
    end

    task automatic test_predict_before_fit();
        send_item(make_item(lsq_pkg::FUNC_PREDICT, 32767, -32768, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, -32768, 32767, 1'b1));
    endtask

    task automatic test_field_extremes();
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, -32768, 32767, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 32767, -32768, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 0, 0, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, -1, -1, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, 32767, 0, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, -32768, -1, 1'b1));
    endtask

    task automatic test_zero_variance();
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 5, 100, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, -32768, 1, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, -32768, 2, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, -32768, 3, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, 1000, 0, 1'b0));
    endtask

    task automatic test_saturation();
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 0, -32768, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 1, 32767, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, 32767, 0, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 0, 32767, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 1, -32768, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, 32767, 0, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 32766, 0, 1'b0));
        send_item(make_item(lsq_pkg::FUNC_SAMPLE, 32767, 16384, 1'b1));
        send_item(make_item(lsq_pkg::FUNC_PREDICT, -32768, 0, 1'b0));
    endtask

    task automatic run_line_set(input int len);
        int style;
        int base;
        int span;
        int gain;
        int offs;
        int x;
        int y;
        style = $urandom_range(3);
        base  = any16();
        span  = ($urandom_range(1)) ? 65535 : $urandom_range(1, 400);
        gain  = int'($urandom_range(2047)) - 1024;
        offs  = int'($urandom_range(4095)) - 2048;
        for (int i = 1; i <= len; i++) begin
            case (style)
                0: begin
                    x = any16();
                    y = any16();
                end
                1: begin
                    x = (span == 65535) ? any16() : clip16(base + $urandom_range(span));
                    y = clip16(((gain * x) >>> 8) + offs + int'($urandom_range(32)) - 16);
                end
                2: begin
                    x = base;
                    y = any16();
                end
                default: begin
                    x = clip16(base + $urandom_range(3));
                    y = any16();
                end
            endcase
            send_item(make_item(lsq_pkg::FUNC_SAMPLE, x, y, i == len));
            if (i != len && $urandom_range(99) < 5)
                send_item(make_item(lsq_pkg::FUNC_PREDICT, any16(), any16(),
                                    1'($urandom_range(1))));
        end
        if ($urandom_range(99) < 60)
            send_item(make_item(lsq_pkg::FUNC_PREDICT, any16(), any16(),
                                1'($urandom_range(1))));
    endtask

    task automatic test_random_sets(input int budget);
        int stop_at;
        int quiet_from;
        int quiet_to;
        int pick;
        int len;
        stop_at    = items_sent + budget;
        quiet_from = items_sent + budget / 3;
        quiet_to   = items_sent + budget / 2;
        while (items_sent < stop_at) begin
            steady = (items_sent >= quiet_from) && (items_sent < quiet_to);
            pick   = $urandom_range(99);
            if (pick < 8) begin
                send_item(make_item(1'($urandom_range(1)), any16(), any16(),
                                    1'($urandom_range(1))));
            end else if (pick < 16) begin
                repeat ($urandom_range(1, 3))
                    send_item(make_item(lsq_pkg::FUNC_PREDICT, any16(), any16(),
                                        1'($urandom_range(1))));
            end else if (pick < 19) begin
                wait_results_done();
            end else begin
                pick = $urandom_range(99);
                if (pick < 3) len = 1;
                else if (pick < 88) len = $urandom_range(2, 16);
                else len = $urandom_range(17, 64);
                run_line_set(len);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        sample_n       = 0;
        acc_x          = 0;
        acc_y          = 0;
        acc_xx         = 0;
        acc_xy         = 0;
        overflow_seen  = 1'b0;
        coef_slope     = 0;
        coef_icpt      = 0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_predict_before_fit();
        test_field_extremes();
        test_zero_variance();
        test_saturation();
        wait_results_done();
        test_random_sets(1628);
        wait_results_done();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("least_squares_line_fit verification clean");
        end else begin
            $display("least_squares_line_fit verification failed");
        end
        $finish;
    end

endmodule
